[rtl/tgo_pkg.sv]
// ----------------------------------------------------------------------------
// Tracking wheel odometry package
// Shared constants, command and status types, and the CORDIC angle table.
// ----------------------------------------------------------------------------
package tgo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 52;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int ATAN_LEN     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL1_SCALE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL2_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_PERP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_PAR        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_X        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y        = 3'd6;

  localparam logic [22:0] ARC_K    = 23'd6588397;
  localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

  localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic load;
    logic scale;
    logic delta;
    logic turn;
    logic arc;
    logic pre;
    logic rot;
    logic gain1;
    logic gain2;
    logic sum;
  } tgo_cmd_t;

  typedef struct packed {
    logic rot_done;
  } tgo_sts_t;

  function automatic logic [ANGLE_BITS:0] atan_angle(logic [4:0] idx);
    logic [32:0] v;
    v = 33'd0;
    if (int'(idx) < ATAN_LEN) begin
      v = {1'b0, ATAN_TURNS[idx]} + (33'd1 << (31 - ANGLE_BITS));
    end
    return (ANGLE_BITS + 1)'(v >> (32 - ANGLE_BITS));
  endfunction

  function automatic logic [ANGLE_BITS-1:0] to_angle(logic [15:0] h);
    logic [39:0] v;
    v = 40'(h);
    if (ANGLE_BITS >= 16) begin
      v = v << (ANGLE_BITS - 16);
    end else begin
      v = v >> (16 - ANGLE_BITS);
    end
    return v[ANGLE_BITS-1:0];
  endfunction

endpackage

[rtl/tgo_if.sv]
// ----------------------------------------------------------------------------
// Odometry stream interfaces
// Valid/ready channels for sensor items and pose results.
// ----------------------------------------------------------------------------
interface tgo_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] wheel1_count;
  logic signed [31:0] wheel2_count;
  logic [15:0]        gyro_heading;

  modport source (output valid, mode, wheel1_count, wheel2_count, gyro_heading,
                  input ready);
  modport sink (input valid, mode, wheel1_count, wheel2_count, gyro_heading,
                output ready);
endinterface

interface tgo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

[rtl/tgo_controller.sv]
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences the datapath through one item and owns both handshakes.
// ----------------------------------------------------------------------------
module tgo_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tgo_pkg::tgo_sts_t sts_i,
  output tgo_pkg::tgo_cmd_t cmd_o
);
  import tgo_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIST  = 10'b0000000010,
    S_DELTA = 10'b0000000100,
    S_TURN  = 10'b0000001000,
    S_ARC   = 10'b0000010000,
    S_PRE   = 10'b0000100000,
    S_ROT   = 10'b0001000000,
    S_GAIN1 = 10'b0010000000,
    S_GAIN2 = 10'b0100000000,
    S_SUM   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   sum_ok;

  assign sum_ok      = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIST;
        end
      end
      S_DIST: begin
        cmd_o.scale = 1'b1;
        state_d     = S_DELTA;
      end
      S_DELTA: begin
        cmd_o.delta = 1'b1;
        state_d     = S_TURN;
      end
      S_TURN: begin
        cmd_o.turn = 1'b1;
        state_d    = S_ARC;
      end
      S_ARC: begin
        cmd_o.arc = 1'b1;
        state_d   = S_PRE;
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        state_d   = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        if (sts_i.rot_done) begin
          state_d = S_GAIN1;
        end
      end
      S_GAIN1: begin
        cmd_o.gain1 = 1'b1;
        state_d     = S_GAIN2;
      end
      S_GAIN2: begin
        cmd_o.gain2 = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        if (sum_ok) begin
          cmd_o.sum   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_to_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_DIST)
    else $error("Accepted transaction did not start the distance step.");

  a_sum_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sum |=> out_valid_q)
    else $error("Result not presented after the position update.");

  a_rot_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT && sts_i.rot_done) |=> state_q == S_GAIN1)
    else $error("Rotation did not hand over to gain scaling.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.sum)
    else $error("Pending result overwritten.");

endmodule

[rtl/tgo_datapath.sv]
// ----------------------------------------------------------------------------
// Odometry datapath
// Configuration registers, distance and arc arithmetic, CORDIC and pose state.
// ----------------------------------------------------------------------------
module tgo_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tgo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tgo_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             mode_i,
  input  logic signed [31:0]               wheel1_count_i,
  input  logic signed [31:0]               wheel2_count_i,
  input  logic [15:0]                      gyro_heading_i,
  input  tgo_pkg::tgo_cmd_t                cmd_i,
  output tgo_pkg::tgo_sts_t                sts_o,
  output logic signed [31:0]               pos_x_o,
  output logic signed [31:0]               pos_y_o,
  output logic [15:0]                      heading_o
);
  import tgo_pkg::*;

  localparam int ZW = ANGLE_BITS + 1;

  logic [23:0]        w1_scale_q, w2_scale_q, arm_perp_q, arm_par_q;
  logic [15:0]        hoff_q;
  logic signed [31:0] start_x_q, start_y_q;

  logic [47:0]        last1_q, last2_q;
  logic [15:0]        gyro_base_q, head_now_q;
  logic signed [31:0] pos_x_q, pos_y_q;

  logic signed [31:0] c1_q, c2_q;
  logic [15:0]        gyro_q, h_q, dth_q;
  logic               rebase_q;
  logic [47:0]        dist1_q, dist2_q;
  logic signed [47:0] d1_q, d2_q;
  logic signed [39:0] t_q;
  logic signed [63:0] a1_q, a2_q;
  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [ZW-1:0]   z_q;
  logic [STEP_W-1:0]  i_q;
  logic               negx_q, negy_q;
  logic [51:0]        hix_q, hiy_q;
  logic [30:0]        lox_q, loy_q;
  logic signed [XY_W+1:0] rx_q, ry_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic [15:0]        out_h_q;

  logic signed [56:0] prod1, prod2;
  logic signed [63:0] r1, r2;
  logic signed [XY_W-1:0] rx0, ry0, xs, ys, px, py;
  logic [ANGLE_BITS-1:0]  ang;
  logic signed [ZW-1:0]   z0, pz, zq, za;
  logic [XY_W-1:0]    mx, my;
  logic [61:0]        lpx, lpy;
  logic [52:0]        magx, magy;
  logic signed [XY_W+2:0] sumx, sumy;
  logic signed [31:0] satx, saty;

  function automatic logic signed [31:0] sat32(logic signed [XY_W+2:0] v);
    logic signed [XY_W+2:0] hi, lo;
    hi = (XY_W + 3)'(33'sh0_7FFF_FFFF);
    lo = -hi - (XY_W + 3)'(1);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign prod1 = c1_q * $signed({1'b0, w1_scale_q});
  assign prod2 = c2_q * $signed({1'b0, w2_scale_q});

  assign r1  = (a1_q + (64'sd1 <<< 35)) >>> 36;
  assign r2  = (a2_q + (64'sd1 <<< 35)) >>> 36;
  assign rx0 = XY_W'(d1_q) - XY_W'(r1);
  assign ry0 = XY_W'(d2_q) + XY_W'(r2);

  assign ang = to_angle(h_q) - ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  assign z0  = ZW'($signed(ang));
  assign zq  = ZW'(1 << (ANGLE_BITS - 2));

  always_comb begin
    px = rx0;
    py = ry0;
    pz = z0;
    if (z0 > zq) begin
      px = -ry0;
      py = rx0;
      pz = z0 - zq;
    end else if (z0 < -zq) begin
      px = ry0;
      py = -rx0;
      pz = z0 + zq;
    end
  end

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign za = ZW'(atan_angle(5'(i_q)));
  assign sts_o.rot_done = (i_q == STEP_W'(CORDIC_STEPS - 1));

  assign mx   = x_q[XY_W-1] ? XY_W'(-x_q) : XY_W'(x_q);
  assign my   = y_q[XY_W-1] ? XY_W'(-y_q) : XY_W'(y_q);
  assign lpx  = (62'(lox_q) * 62'(GAIN_Q31) + (62'd1 << 30)) >> 31;
  assign lpy  = (62'(loy_q) * 62'(GAIN_Q31) + (62'd1 << 30)) >> 31;
  assign magx = 53'(hix_q) + 53'(lpx);
  assign magy = 53'(hiy_q) + 53'(lpy);

  assign sumx = (XY_W + 3)'(pos_x_q) + (XY_W + 3)'(rx_q);
  assign sumy = (XY_W + 3)'(pos_y_q) + (XY_W + 3)'(ry_q);
  assign satx = sat32(sumx);
  assign saty = sat32(sumy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_scale_q <= 24'd65536;
      w2_scale_q <= 24'd65536;
      arm_perp_q <= '0;
      arm_par_q  <= '0;
      hoff_q     <= '0;
      start_x_q  <= '0;
      start_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WHEEL1_SCALE:   w1_scale_q <= cfg_data_i[23:0];
        REG_WHEEL2_SCALE:   w2_scale_q <= cfg_data_i[23:0];
        REG_ARM_PERP:       arm_perp_q <= cfg_data_i[23:0];
        REG_ARM_PAR:        arm_par_q  <= cfg_data_i[23:0];
        REG_HEADING_OFFSET: hoff_q     <= cfg_data_i[15:0];
        REG_START_X:        start_x_q  <= $signed(cfg_data_i[31:0]);
        REG_START_Y:        start_y_q  <= $signed(cfg_data_i[31:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last1_q     <= '0;
      last2_q     <= '0;
      gyro_base_q <= '0;
      head_now_q  <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      if (cmd_i.load && mode_i) begin
        gyro_base_q <= gyro_heading_i;
        head_now_q  <= hoff_q;
        pos_x_q     <= start_x_q;
        pos_y_q     <= start_y_q;
      end
      if (cmd_i.scale && rebase_q) begin
        last1_q <= prod1[47:0];
        last2_q <= prod2[47:0];
      end
      if (cmd_i.delta) begin
        last1_q <= dist1_q;
        last2_q <= dist2_q;
      end
      if (cmd_i.sum) begin
        pos_x_q    <= satx;
        pos_y_q    <= saty;
        head_now_q <= h_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c1_q     <= wheel1_count_i;
      c2_q     <= wheel2_count_i;
      gyro_q   <= gyro_heading_i;
      rebase_q <= mode_i;
    end
    if (cmd_i.scale) begin
      dist1_q <= prod1[47:0];
      dist2_q <= prod2[47:0];
      h_q     <= gyro_q - gyro_base_q + hoff_q;
    end
    if (cmd_i.delta) begin
      d1_q  <= $signed(dist1_q - last1_q);
      d2_q  <= $signed(dist2_q - last2_q);
      dth_q <= h_q - head_now_q;
    end
    if (cmd_i.turn) begin
      t_q <= 40'($signed(dth_q)) * $signed({17'd0, ARC_K});
    end
    if (cmd_i.arc) begin
      a1_q <= 64'($signed({1'b0, arm_perp_q})) * 64'(t_q);
      a2_q <= 64'($signed({1'b0, arm_par_q})) * 64'(t_q);
    end
    if (cmd_i.pre) begin
      x_q <= px;
      y_q <= py;
      z_q <= pz;
      i_q <= '0;
    end
    if (cmd_i.rot) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - za;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + za;
      end
      i_q <= i_q + STEP_W'(1);
    end
    if (cmd_i.gain1) begin
      negx_q <= x_q[XY_W-1];
      negy_q <= y_q[XY_W-1];
      hix_q  <= 52'(mx[XY_W-1:31]) * 52'(GAIN_Q31);
      hiy_q  <= 52'(my[XY_W-1:31]) * 52'(GAIN_Q31);
      lox_q  <= mx[30:0];
      loy_q  <= my[30:0];
    end
    if (cmd_i.gain2) begin
      rx_q <= negx_q ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
      ry_q <= negy_q ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
    end
    if (cmd_i.sum) begin
      out_x_q <= satx;
      out_y_q <= saty;
      out_h_q <= h_q;
    end
  end

  assign pos_x_o   = out_x_q;
  assign pos_y_o   = out_y_q;
  assign heading_o = out_h_q;

endmodule

[rtl/tracking_wheel_gyro_odometry.sv]
// ----------------------------------------------------------------------------
// Tracking wheel odometry with gyro heading
// Integrates two tracking wheels and a gyro yaw into a saturating Q16.16 pose.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_s     sink       mode, wheel1_count, wheel2_count, gyro_heading
//  out_m    source     pos_x, pos_y, heading
//  cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// One transaction runs from acceptance through the distance, delta, turn,
// arc, pre-rotation, CORDIC rotation, gain and pose sum steps; the
// CORDIC iterations run on a single shift-add stage. The next item
// is accepted once the previous one leaves the datapath, while its result waits
// in the output register. Reset clears the pose and baselines and returns the
// configuration to its defaults. A stalled output holds the datapath in its
// final step.
module tracking_wheel_gyro_odometry (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tgo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tgo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tgo_in_if.sink                         in_s,
  tgo_out_if.source                      out_m
);
  import tgo_pkg::*;

  tgo_cmd_t cmd;
  tgo_sts_t sts;

  tgo_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tgo_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (in_s.mode),
    .wheel1_count_i (in_s.wheel1_count),
    .wheel2_count_i (in_s.wheel2_count),
    .gyro_heading_i (in_s.gyro_heading),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pos_x_o        (out_m.pos_x),
    .pos_y_o        (out_m.pos_y),
    .heading_o      (out_m.heading)
  );

endmodule
